@@ rtl/srb_pkg.sv @@
// Shared types and constants for the sliding window reorder buffer.
// No dependencies; the top level, the checker and the testbench import this package.
package srb_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned WIN_W     = 7;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_FRONT = 2'd2,
    CMD_POP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [IDX_W-1:0]  slot_index;
    logic [DATA_W-1:0] payload;
    logic [LEN_W-1:0]  payload_len;
  } in_word_t;

  typedef struct packed {
    logic                 ok;
    logic                 occupied;
    logic [DATA_W-1:0]    front_data;
    logic [LEN_W-1:0]     front_len;
    logic [CNT_OUT_W-1:0] occupied_count;
  } out_word_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_slots;
  } cfg_word_t;

endpackage

@@ rtl/srb_chan_if.sv @@
// Valid/ready channel carrying one word of a chosen type.
// Used for the command, result and configuration channels; types come from srb_pkg.
interface srb_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

@@ rtl/sliding_window_reorder_buffer_top.sv @@
// Sliding window reorder buffer: slot storage, head pointer, occupancy count.
// Depends on srb_pkg and srb_chan_if.
//
// One command word is accepted per cycle once the sweep is done, unless the
// pipeline is stalled. The slot memory is read at the accepting edge into the
// update stage; the update, the write-back and the loading of the result word
// into the output register happen at the edge where the update stage advances. A write-back to the slot
// that the following command reads is forwarded, so back-to-back commands on
// the same slot see each other. The result register decouples the sides:
// out ready low stalls the pipeline only when both the update stage and the
// result register are full. After reset the block sweeps the slot memory,
// one slot per cycle, and holds in_chan.ready low until the sweep is done;
// configuration writes are taken at any time. The user must write window_slots
// only while the block is idle; the block itself does not enforce this.
module sliding_window_reorder_buffer_top #(
  parameter int unsigned MAX_SLOTS    = 64,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst_n,
  srb_chan_if.sink   in_chan,
  srb_chan_if.source out_chan,
  srb_chan_if.sink   cfg_chan
);
  import srb_pkg::*;

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);
  localparam logic [SW-1:0] RING_SIZE = SW'(MAX_SLOTS);

  typedef struct packed {
    logic                    valid;
    logic [LEN_W-1:0]        len;
    logic [PAYLOAD_BITS-1:0] data;
  } slot_t;

  // slot memory
  slot_t mem [MAX_SLOTS];

  // control and state registers
  logic [WIN_W-1:0] window_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             clr_active_r;
  logic [AW-1:0]    clr_addr_r;

  // update stage
  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic                    s1_ok_r;
  logic [AW-1:0]           s1_addr_r;
  logic [PAYLOAD_BITS-1:0] s1_data_r;
  logic [LEN_W-1:0]        s1_len_r;
  slot_t                   rd_word_r;

  // last write-back, for forwarding
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  slot_t         fwd_word_r;

  // result register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic          in_ready, in_acc, s1_adv;
  logic          idx_ok;
  logic [SW-1:0] ring_sum;
  logic [AW-1:0] ring_pos, rd_addr;
  slot_t         cur;
  logic          s1_wr;
  slot_t         s1_wr_word;
  out_word_t     result;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;

  // handshakes
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_chan.valid && in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.word  = out_word_r;

  // window check and ring address of the incoming word
  always_comb begin
    idx_ok = (IDX_W'(window_r) > in_chan.word.slot_index) &&
             (32'(in_chan.word.slot_index) < MAX_SLOTS);
    ring_sum = SW'(head_r) + SW'(in_chan.word.slot_index);
    if (ring_sum >= RING_SIZE) begin
      ring_pos = AW'(ring_sum - RING_SIZE);
    end else begin
      ring_pos = AW'(ring_sum);
    end
    if (in_chan.word.command == CMD_ADD || in_chan.word.command == CMD_QUERY) begin
      rd_addr = ring_pos;
    end else begin
      rd_addr = head_r;
    end
    head_nxt = head_r;
    if (in_acc && in_chan.word.command == CMD_POP) begin
      head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
    end
  end

  // update stage: merge forwarded slot, decide write-back and result
  always_comb begin
    cur = rd_word_r;
    if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      cur = fwd_word_r;
    end
    s1_wr      = 1'b0;
    s1_wr_word = '0;
    count_nxt  = count_r;
    result     = '0;
    result.ok  = s1_ok_r;
    unique case (s1_cmd_r)
      CMD_ADD: begin
        if (s1_ok_r) begin
          s1_wr           = 1'b1;
          s1_wr_word      = '{valid: 1'b1, len: s1_len_r, data: s1_data_r};
          result.occupied = cur.valid;
          if (!cur.valid) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      CMD_QUERY: begin
        result.occupied = s1_ok_r && cur.valid;
      end
      CMD_FRONT: begin
        result.occupied = cur.valid;
        if (cur.valid) begin
          result.front_data = DATA_W'(cur.data);
          result.front_len  = cur.len;
        end
      end
      CMD_POP: begin
        s1_wr           = 1'b1;
        result.occupied = cur.valid;
        if (cur.valid && count_r != '0) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
    result.occupied_count = CNT_OUT_W'(count_nxt);
  end

  // memory write port: clearing sweep or write-back
  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && s1_wr;
      mem_waddr = s1_addr_r;
      mem_wdata = s1_wr_word;
    end
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // capture accepted word into the update stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_chan.word.command;
      s1_ok_r   <= (in_chan.word.command == CMD_FRONT ||
                    in_chan.word.command == CMD_POP) ? 1'b1 : idx_ok;
      s1_addr_r <= rd_addr;
      s1_data_r <= in_chan.word.payload[PAYLOAD_BITS-1:0];
      s1_len_r  <= in_chan.word.payload_len;
    end
    if (mem_we) begin
      fwd_addr_r <= mem_waddr;
      fwd_word_r <= mem_wdata;
    end
    if (s1_adv) begin
      out_word_r <= result;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RESET;
      head_r       <= '0;
      count_r      <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        window_r <= cfg_chan.word.window_slots;
      end
      // sweep the memory once after reset
      if (clr_active_r) begin
        if (clr_addr_r == LAST_SLOT) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
      end
      head_r <= head_nxt;
      if (s1_adv) begin
        count_r <= count_nxt;
      end
      // hold the last write only when it came from the update stage
      if (mem_we) begin
        fwd_valid_r <= !clr_active_r;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/srb_checker.sv @@
// Port-level checks for the sliding window reorder buffer, bound to the top level.
// Depends on srb_pkg and sliding_window_reorder_buffer_top.
module srb_checker #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input srb_pkg::out_word_t out_word
);
  import srb_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // drop ready while the slot memory is swept after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("command accepted during memory sweep");

  // a new result follows an accepted command, through the update stage and the result register
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a command two cycles earlier");

  // a refused command reports nothing else
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.ok |-> !out_word.occupied &&
      out_word.front_data == '0 && out_word.front_len == '0)
    else $error("refused command carries slot data");

  // occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_word.occupied_count) <= MAX_SLOTS)
    else $error("occupied count above ring size");

endmodule

bind sliding_window_reorder_buffer_top srb_checker #(
  .MAX_SLOTS(MAX_SLOTS)
) u_srb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.word)
);

@@ tb/tb_sliding_window_reorder_buffer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window reorder buffer top level.
// Depends on srb_pkg and srb_chan_if; predicts every result word and checks it in order.
module tb_sliding_window_reorder_buffer_top;
  import srb_pkg::*;

  localparam int unsigned RING_SLOTS  = 64;
  localparam int unsigned PIPE_SETTLE = 4;
  localparam int unsigned HANG_LIMIT  = 2000;

  logic clk;
  logic rst_n;

  srb_chan_if #(.word_t(in_word_t))  in_chan  ();
  srb_chan_if #(.word_t(out_word_t)) out_chan ();
  srb_chan_if #(.word_t(cfg_word_t)) cfg_chan ();

  sliding_window_reorder_buffer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Shadow copy of the window contents
  logic                 slot_full [RING_SLOTS];
  logic [DATA_W-1:0]    slot_data [RING_SLOTS];
  logic [LEN_W-1:0]     slot_len  [RING_SLOTS];
  logic [5:0]           head_pos;
  logic [CNT_OUT_W-1:0] fill_count;
  logic [WIN_W-1:0]     window_reg;

  out_word_t   pending_results[$];
  int unsigned fail_count;
  int unsigned stall_cycles;
  bit          bursts_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow window and return the word it should produce
  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t   r;
    logic [5:0]  pos;
    int unsigned span;
    r    = '0;
    r.ok = 1'b1;
    span = (window_reg > RING_SLOTS) ? RING_SLOTS : window_reg;
    case (w.command)
      CMD_ADD, CMD_QUERY: begin
        if (w.slot_index >= span) begin
          r.ok = 1'b0;
        end else begin
          pos        = head_pos + w.slot_index[5:0];
          r.occupied = slot_full[pos];
          if (w.command == CMD_ADD) begin
            slot_data[pos] = w.payload;
            slot_len[pos]  = w.payload_len;
            if (!slot_full[pos]) begin
              slot_full[pos] = 1'b1;
              fill_count++;
            end
          end
        end
      end
      CMD_FRONT: begin
        if (slot_full[head_pos]) begin
          r.occupied   = 1'b1;
          r.front_data = slot_data[head_pos];
          r.front_len  = slot_len[head_pos];
        end
      end
      default: begin
        // Pop: retire the head slot even when it is empty
        if (slot_full[head_pos]) begin
          r.occupied = 1'b1;
          if (fill_count != 0) fill_count--;
        end
        slot_full[head_pos] = 1'b0;
        slot_data[head_pos] = '0;
        slot_len[head_pos]  = '0;
        head_pos++;
      end
    endcase
    r.occupied_count = fill_count;
    return r;
  endfunction

  function automatic in_word_t make_cmd(input cmd_t c, input logic [IDX_W-1:0] idx,
                                        input logic [DATA_W-1:0] pay,
                                        input logic [LEN_W-1:0] len);
    in_word_t w;
    w.command     = c;
    w.slot_index  = idx;
    w.payload     = pay;
    w.payload_len = len;
    return w;
  endfunction

  // Send one command word, with an occasional gap ahead of it
  task automatic send_cmd(input in_word_t w);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.word  <= w;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(predict_result(w));
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write the window register once the block is idle
  task automatic write_window(input logic [WIN_W-1:0] slots);
    drain_results();
    cfg_chan.word  <= cfg_word_t'(slots);
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    window_reg = slots;
  endtask

  // Mostly well-formed traffic: in-window adds and queries mixed with fronts and pops
  task automatic run_random_phase(input int unsigned items, input logic [WIN_W-1:0] slots,
                                  input bit pause_midway);
    int unsigned span;
    int unsigned pick;
    cmd_t        c;
    logic [IDX_W-1:0] idx;
    write_window(slots);
    span = (slots > RING_SLOTS) ? RING_SLOTS : slots;
    for (int unsigned i = 0; i < items; i++) begin
      if (pause_midway && i == items / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 40) c = CMD_ADD;
      else if (pick < 60) c = CMD_QUERY;
      else if (pick < 75) c = CMD_FRONT;
      else c = CMD_POP;
      if (span != 0 && $urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, span - 1));
      else idx = IDX_W'($urandom_range(0, 255));
      send_cmd(make_cmd(c, idx, {$urandom, $urandom}, LEN_W'($urandom_range(0, 255))));
    end
  endtask

  // Field extremes, overwrite, out-of-window offsets and pop of an empty head
  task automatic test_edge_cases();
    send_cmd(make_cmd(CMD_FRONT, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_QUERY, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_ADD, 8'd0, '1, 8'hFF));
    send_cmd(make_cmd(CMD_ADD, 8'd0, 64'h5, 8'h01));
    send_cmd(make_cmd(CMD_FRONT, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_QUERY, 8'd63, '0, '0));
    send_cmd(make_cmd(CMD_QUERY, 8'd64, '0, '0));
    send_cmd(make_cmd(CMD_ADD, 8'd255, '1, 8'hFF));
    send_cmd(make_cmd(CMD_ADD, 8'd63, 64'h8000_0000_0000_0000, 8'h80));
    send_cmd(make_cmd(CMD_POP, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_POP, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_FRONT, 8'd0, '0, '0));
  endtask

  // A closed window refuses every add and query
  task automatic test_window_closed();
    write_window(7'd0);
    send_cmd(make_cmd(CMD_ADD, 8'd0, 64'h1234, 8'h12));
    send_cmd(make_cmd(CMD_QUERY, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_FRONT, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_POP, 8'd0, '0, '0));
  endtask

  // A window register above the ring size behaves as the full ring
  task automatic test_window_saturates();
    write_window(7'd127);
    send_cmd(make_cmd(CMD_ADD, 8'd64, 64'hDEAD_BEEF, 8'h40));
    send_cmd(make_cmd(CMD_ADD, 8'd63, 64'hCAFE_F00D_0000_0001, 8'h7F));
    send_cmd(make_cmd(CMD_QUERY, 8'd63, '0, '0));
  endtask

  // Slots left outside a shrunk window keep their data and come back as the head moves
  task automatic test_window_shrinks();
    write_window(7'd64);
    send_cmd(make_cmd(CMD_ADD, 8'd1, 64'h0123_4567_89AB_CDEF, 8'h33));
    write_window(7'd1);
    send_cmd(make_cmd(CMD_QUERY, 8'd1, '0, '0));
    send_cmd(make_cmd(CMD_POP, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_QUERY, 8'd0, '0, '0));
    send_cmd(make_cmd(CMD_FRONT, 8'd0, '0, '0));
  endtask

  task automatic test_random_full_window();
    run_random_phase(150, 7'd64, 1'b1);
  endtask

  task automatic test_random_small_windows();
    run_random_phase(40, 7'd1, 1'b0);
    run_random_phase(50, WIN_W'($urandom_range(2, 63)), 1'b0);
    run_random_phase(50, WIN_W'($urandom_range(2, 63)), 1'b0);
  endtask

  task automatic test_random_odd_windows();
    run_random_phase(60, 7'd127, 1'b0);
    run_random_phase(20, 7'd0, 1'b0);
  endtask

  task automatic test_random_no_idling();
    bursts_on = 1'b0;
    run_random_phase(150, 7'd64, 1'b0);
  endtask

  // Result side: stall in random bursts while idling is enabled
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time,
                 out_chan.word);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", DATA_W'(want.ok), DATA_W'(out_chan.word.ok));
        check_field("occupied", DATA_W'(want.occupied), DATA_W'(out_chan.word.occupied));
        check_field("front_data", want.front_data, out_chan.word.front_data);
        check_field("front_len", DATA_W'(want.front_len), DATA_W'(out_chan.word.front_len));
        check_field("occupied_count", DATA_W'(want.occupied_count),
                    DATA_W'(out_chan.word.occupied_count));
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.word   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.word  <= '0;
    fail_count     = 0;
    bursts_on      = 1'b1;
    head_pos       = '0;
    fill_count     = '0;
    window_reg     = WINDOW_RESET;
    for (int i = 0; i < RING_SLOTS; i++) begin
      slot_full[i] = 1'b0;
      slot_data[i] = '0;
      slot_len[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_window_closed();
    test_window_saturates();
    test_window_shrinks();
    test_random_full_window();
    test_random_small_windows();
    test_random_odd_windows();
    test_random_no_idling();

    drain_results();
    repeat (4 * PIPE_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
